FILE: design/primitive_root_search_macros.svh
// Assertion macros shared by the primitive root search design
`ifndef PRIMITIVE_ROOT_SEARCH_MACROS_SVH
`define PRIMITIVE_ROOT_SEARCH_MACROS_SVH
// Check a property on every clock edge outside reset
`define PRS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included
`define PRS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: design/prs_pkg.sv
// Package with widths and result type of the primitive root search
`default_nettype none
package prs_pkg;
	localparam int unsigned ModulusBits = 20;
	localparam int unsigned FactorMax = 16;
	localparam int unsigned FactorIdxBits = 4;
	localparam int unsigned FactorCntBits = 5;
	typedef logic [ModulusBits-1:0] word_t;
	typedef struct packed {
		logic  has_root;
		word_t totient;
		word_t smallest_root;
		word_t root_count;
	} result_t;
endpackage
`default_nettype wire

FILE: design/prs_stream_if.sv
// Valid/ready channel that carries one payload
`default_nettype none
interface prs_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: design/primitive_root_search.sv
// Top level of the primitive root search
// Takes one modulus n and returns has_root, phi(n), the least primitive root and phi(phi(n)).
// Divisions go through one restoring divider; each modular product is registered and
// reduced modulo n by a separate bit-serial remainder unit. Trial division by candidates
// up to sqrt, factoring phi(n) and the modular exponentiations for every candidate root
// make up the work for each modulus. The block accepts one modulus at a time and the
// result register holds until it is taken.
`default_nettype none
`include "primitive_root_search_macros.svh"
module primitive_root_search (
	input wire logic clk,
	input wire logic arst_n,
	prs_stream_if.sink   modulus_ch,
	prs_stream_if.source result_ch
);
	import prs_pkg::*;
	localparam int unsigned WideBits = 2 * ModulusBits;

	typedef enum logic [5:0] {
		S_IDLE,
		// totient by trial division (value x_q, candidate i_q, acc res_q)
		S_TOT_CHK, S_TOT_DIV, S_TOT_SQ, S_TOT_SQW, S_TOT_STRIP, S_TOT_STRIPW,
		S_TOT_APPLY, S_TOT_APPLYW, S_TOT_END, S_TOT_ENDW,
		// odd prime power test
		S_OPP_START, S_OPP_CHK, S_OPP_DIVW, S_OPP_STRIP, S_OPP_STRIPW,
		// factor phi
		S_FAC_START,
		// candidate test
		S_CAND, S_EXP_NEXT, S_EXP_DIVW, S_EXP_SETUP, S_PM_STEP, S_PM_MULW, S_PM_SQW,
		S_NEXT_CAND,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		T_PHI, T_COUNT, T_FACTOR
	} tjob_t;

	state_t state_q;
	tjob_t  tjob_q;
	word_t  n_q, phi_q, x_q, i_q, res_q, g_q, cnt_q;
	logic   has_q, opp_half_q;
	word_t  fac_q [FactorMax];
	logic [FactorCntBits-1:0] nf_q;
	logic [FactorCntBits-1:0] fi_q;
	word_t  base_q, e_q, pr_q;
	logic   ok_q;
	result_t res_out_q;
	logic    out_valid_q;

	// Shared divider
	logic  div_start;
	word_t div_a, div_b, div_quo, div_rem;
	logic  div_busy;
	logic [WideBits-1:0] prod;
	word_t mul_a, mul_b;

	prs_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .busy(div_busy), .quotient(div_quo), .remainder(div_rem)
	);

	// Reduce products (below n^2 < 2^40) modulo n with a bit-serial remainder unit
	logic [WideBits-1:0] wrem_q;
	logic [WideBits-1:0] wtrial;
	logic [$clog2(WideBits+1)-1:0] wcnt_q;
	logic [WideBits-1:0] wnum_q;
	logic wbusy_q;
	logic wstart;

	assign prod = WideBits'(mul_a) * WideBits'(mul_b);
	assign wtrial = {wrem_q[WideBits-2:0], wnum_q[WideBits-1]} - WideBits'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbusy_q <= 1'b0;
			wcnt_q <= '0;
		end else if (wstart) begin
			wbusy_q <= 1'b1;
			wcnt_q <= ($clog2(WideBits+1))'(WideBits);
		end else if (wbusy_q) begin
			wcnt_q <= wcnt_q - 1'b1;
			if (wcnt_q == ($clog2(WideBits+1))'(1)) wbusy_q <= 1'b0;
		end
	end

	// Multiplier is registered into wnum_q; the reduction is bit-serial
	always_ff @(posedge clk) begin
		if (wstart) begin
			wnum_q <= prod;
			wrem_q <= '0;
		end else if (wbusy_q) begin
			wnum_q <= {wnum_q[WideBits-2:0], 1'b0};
			if (!wtrial[WideBits-1] &&
			    {wrem_q[WideBits-2:0], wnum_q[WideBits-1]} >= WideBits'(n_q))
				wrem_q <= wtrial;
			else
				wrem_q <= {wrem_q[WideBits-2:0], wnum_q[WideBits-1]};
		end
	end

	logic [WideBits-1:0] sq_i;
	assign sq_i = WideBits'(i_q) * WideBits'(i_q);

	always_comb begin
		div_start = 1'b0;
		div_a = x_q;
		div_b = i_q;
		wstart = 1'b0;
		mul_a = pr_q;
		mul_b = base_q;
		case (state_q)
			S_TOT_DIV, S_TOT_STRIP, S_OPP_CHK, S_OPP_STRIP: div_start = 1'b1;
			S_TOT_APPLY: begin
				div_start = 1'b1;
				div_a = res_q;
			end
			S_TOT_END: begin
				div_start = 1'b1;
				div_a = res_q;
				div_b = x_q;
			end
			S_EXP_NEXT: begin
				div_start = 1'b1;
				div_a = phi_q;
				div_b = fac_q[fi_q[FactorIdxBits-1:0]];
			end
			S_PM_STEP: begin
				// start a product only while exponent bits remain
				if (e_q != '0) wstart = 1'b1;
				if (!e_q[0]) begin
					mul_a = base_q;
				end
			end
			S_PM_MULW: begin
				if (!wbusy_q) begin
					wstart = 1'b1;
					mul_a = base_q;
				end
			end
			default: ;
		endcase
	end

	assign modulus_ch.ready = (state_q == S_IDLE);
	assign result_ch.valid = out_valid_q;
	assign result_ch.payload = res_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			tjob_q <= T_PHI;
			nf_q <= '0;
			fi_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (modulus_ch.valid) begin
						n_q <= modulus_ch.payload;
						x_q <= modulus_ch.payload;
						res_q <= modulus_ch.payload;
						i_q <= word_t'(2);
						tjob_q <= T_PHI;
						nf_q <= '0;
						state_q <= S_TOT_SQ;
					end
				end
				// loop head: i*i <= x ?
				S_TOT_SQ: begin
					if (sq_i <= WideBits'(x_q)) state_q <= S_TOT_DIV;
					else state_q <= S_TOT_END;
				end
				S_TOT_DIV: state_q <= S_TOT_SQW;
				S_TOT_SQW: begin
					if (!div_busy) begin
						if (div_rem == '0) begin
							if (tjob_q == T_FACTOR && nf_q < FactorCntBits'(FactorMax)) begin
								fac_q[nf_q[FactorIdxBits-1:0]] <= i_q;
								nf_q <= nf_q + 1'b1;
							end
							x_q <= div_quo;
							state_q <= S_TOT_STRIP;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_TOT_SQ;
						end
					end
				end
				S_TOT_STRIP: state_q <= S_TOT_STRIPW;
				S_TOT_STRIPW: begin
					if (!div_busy) begin
						if (div_rem == '0) begin
							x_q <= div_quo;
							state_q <= S_TOT_STRIP;
						end else begin
							state_q <= S_TOT_APPLY;
						end
					end
				end
				S_TOT_APPLY: state_q <= S_TOT_APPLYW;
				S_TOT_APPLYW: begin
					if (!div_busy) begin
						if (tjob_q != T_FACTOR) res_q <= word_t'(div_quo * (i_q - 1'b1));
						i_q <= i_q + 1'b1;
						state_q <= S_TOT_SQ;
					end
				end
				S_TOT_END: begin
					if (x_q > word_t'(1)) begin
						if (tjob_q == T_FACTOR) begin
							if (nf_q < FactorCntBits'(FactorMax)) begin
								fac_q[nf_q[FactorIdxBits-1:0]] <= x_q;
								nf_q <= nf_q + 1'b1;
							end
							state_q <= S_FAC_START;
						end else begin
							state_q <= S_TOT_ENDW;
						end
					end else begin
						state_q <= (tjob_q == T_FACTOR) ? S_FAC_START : S_TOT_ENDW;
					end
				end
				S_TOT_ENDW: begin
					if (!div_busy) begin
						logic [WideBits-1:0] fin;
						fin = (x_q > word_t'(1)) ? WideBits'(div_quo) * WideBits'(x_q - 1'b1)
						                          : WideBits'(res_q);
						if (tjob_q == T_PHI) begin
							phi_q <= word_t'(fin);
							if (n_q == word_t'(2) || n_q == word_t'(4)) begin
								has_q <= 1'b1;
								tjob_q <= T_FACTOR;
								x_q <= word_t'(fin);
								i_q <= word_t'(2);
								state_q <= S_TOT_SQ;
							end else begin
								opp_half_q <= 1'b0;
								x_q <= n_q;
								state_q <= S_OPP_START;
							end
						end else begin
							cnt_q <= word_t'(fin);
							state_q <= S_OUT;
						end
					end
				end
				// odd prime power test on x_q
				S_OPP_START: begin
					if (x_q < word_t'(3) || !x_q[0]) begin
						if (!opp_half_q && !n_q[0]) begin
							opp_half_q <= 1'b1;
							x_q <= n_q >> 1;
						end else begin
							has_q <= 1'b0;
							state_q <= S_OUT;
							g_q <= '0;
							cnt_q <= '0;
						end
					end else begin
						i_q <= word_t'(3);
						state_q <= S_OPP_CHK;
					end
				end
				S_OPP_CHK: state_q <= S_OPP_DIVW;
				S_OPP_DIVW: begin
					if (!div_busy) begin
						if (div_rem == '0) begin
							x_q <= div_quo;
							state_q <= S_OPP_STRIP;
						end else if (WideBits'(i_q + 2'd2) * WideBits'(i_q + 2'd2)
						             <= WideBits'(x_q)) begin
							i_q <= i_q + 2'd2;
							state_q <= S_OPP_CHK;
						end else begin
							has_q <= 1'b1;
							tjob_q <= T_FACTOR;
							x_q <= phi_q;
							i_q <= word_t'(2);
							state_q <= S_TOT_SQ;
						end
					end
				end
				S_OPP_STRIP: begin
					if (x_q == word_t'(1)) begin
						has_q <= 1'b1;
						tjob_q <= T_FACTOR;
						x_q <= phi_q;
						i_q <= word_t'(2);
						state_q <= S_TOT_SQ;
					end else begin
						state_q <= S_OPP_STRIPW;
					end
				end
				S_OPP_STRIPW: begin
					if (!div_busy) begin
						if (div_rem == '0) begin
							x_q <= div_quo;
							state_q <= S_OPP_STRIP;
						end else if (!opp_half_q && !n_q[0]) begin
							opp_half_q <= 1'b1;
							x_q <= n_q >> 1;
							state_q <= S_OPP_START;
						end else begin
							has_q <= 1'b0;
							g_q <= '0;
							cnt_q <= '0;
							state_q <= S_OUT;
						end
					end
				end
				S_FAC_START: begin
					g_q <= word_t'(1);
					state_q <= S_CAND;
				end
				// candidate g_q: exponent phi first, then phi/q for each factor
				S_CAND: begin
					if (g_q >= n_q) begin
						g_q <= '0;
						tjob_q <= T_COUNT;
						x_q <= phi_q;
						res_q <= phi_q;
						i_q <= word_t'(2);
						state_q <= S_TOT_SQ;
					end else begin
						fi_q <= '0;
						e_q <= phi_q;
						ok_q <= 1'b1;
						state_q <= S_EXP_SETUP;
					end
				end
				S_EXP_NEXT: state_q <= S_EXP_DIVW;
				S_EXP_DIVW: begin
					if (!div_busy) begin
						e_q <= div_quo;
						fi_q <= fi_q + 1'b1;
						state_q <= S_EXP_SETUP;
					end
				end
				S_EXP_SETUP: begin
					base_q <= g_q;
					pr_q <= (n_q == word_t'(1)) ? '0 : word_t'(1);
					state_q <= S_PM_STEP;
				end
				S_PM_STEP: begin
					if (e_q == '0) begin
						// power done: pr_q holds g^e mod n
						if (fi_q == '0) begin
							if (pr_q != word_t'(1)) ok_q <= 1'b0;
						end else if (pr_q == word_t'(1)) begin
							ok_q <= 1'b0;
						end
						state_q <= S_NEXT_CAND;
					end else begin
						state_q <= e_q[0] ? S_PM_MULW : S_PM_SQW;
					end
				end
				S_PM_MULW: begin
					if (!wbusy_q) begin
						pr_q <= word_t'(wrem_q);
						state_q <= S_PM_SQW;
					end
				end
				S_PM_SQW: begin
					if (!wbusy_q && !wstart) begin
						base_q <= word_t'(wrem_q);
						e_q <= e_q >> 1;
						state_q <= S_PM_STEP;
					end
				end
				S_NEXT_CAND: begin
					if (!ok_q) begin
						g_q <= g_q + 1'b1;
						state_q <= S_CAND;
					end else if (fi_q < nf_q) begin
						state_q <= S_EXP_NEXT;
					end else begin
						tjob_q <= T_COUNT;
						x_q <= phi_q;
						res_q <= phi_q;
						i_q <= word_t'(2);
						state_q <= S_TOT_SQ;
					end
				end
				S_OUT: begin
					if (!out_valid_q || result_ch.ready) begin
						res_out_q.has_root <= has_q;
						res_out_q.totient <= phi_q;
						res_out_q.smallest_root <= has_q ? g_q : '0;
						res_out_q.root_count <= has_q ? cnt_q : '0;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (out_valid_q && result_ch.ready && state_q != S_OUT) out_valid_q <= 1'b0;
		end
	end

	`PRS_ASSERT(a_ready_idle, clk, arst_n, modulus_ch.ready |-> !div_busy && !wbusy_q,
		"arithmetic busy while idle")
	`PRS_ASSERT(a_nf_bound, clk, arst_n, nf_q <= FactorCntBits'(FactorMax),
		"factor count overflow")
	`PRS_ASSERT(a_no_root_zero, clk, arst_n,
		result_ch.valid && !result_ch.payload.has_root |-> result_ch.payload.smallest_root == '0,
		"root reported without existence")
endmodule
`default_nettype wire

FILE: design/prs_divider.sv
// Shared restoring divider, one quotient bit per cycle
`default_nettype none
module prs_divider (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire prs_pkg::word_t dividend,
	input  wire prs_pkg::word_t divisor,
	output logic                busy,
	output prs_pkg::word_t      quotient,
	output prs_pkg::word_t      remainder
);
	import prs_pkg::*;
	localparam int unsigned CntBits = $clog2(ModulusBits + 1);
	logic [CntBits-1:0] cnt_q;
	word_t              quo_q;
	logic [ModulusBits:0] rem_q;
	word_t              dvs_q;
	logic [ModulusBits:0] trial;
	logic [ModulusBits:0] shifted;

	assign shifted = {rem_q[ModulusBits-1:0], quo_q[ModulusBits-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy <= 1'b0;
		end else if (start) begin
			cnt_q <= CntBits'(ModulusBits);
			busy <= 1'b1;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntBits'(1)) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[ModulusBits]) begin
				rem_q <= trial;
				quo_q <= {quo_q[ModulusBits-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[ModulusBits-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q[ModulusBits-1:0];
endmodule
`default_nettype wire
